[src/etcf_pkg.sv]
// Package for the epoch-to-calendar converter: constants, pipeline record and helper functions.
package etcf_pkg;

    localparam int unsigned NSTG = 14;

    // configuration register indexes
    localparam logic CFG_ZONE = 1'b0;
    localparam logic CFG_DST  = 1'b1;

    localparam longint unsigned MS_DAY   = 64'd86400000;
    localparam longint unsigned CYC_DAYS = 64'd146097;
    // bias that keeps the local day count positive: 58 times the days in 400 years
    localparam longint unsigned DP_OFF   = 64'd58 * CYC_DAYS;
    // 1970-01-01 counted from 0000-03-01, reduced to one cycle
    localparam longint unsigned MAR_OFF  = 64'd719468 - 64'd4 * CYC_DAYS;

    // reciprocals, rounded up, exact for the operand ranges used
    localparam int unsigned     SH_CYC  = 43;
    localparam longint unsigned K_CYC   = ((64'd1 << SH_CYC) + CYC_DAYS - 1) / CYC_DAYS;
    localparam int unsigned     SH_1000 = 37;
    localparam longint unsigned K_1000  = ((64'd1 << SH_1000) + 64'd999) / 64'd1000;
    localparam int unsigned     SH_60   = 24;
    localparam longint unsigned K_60    = ((64'd1 << SH_60) + 64'd59) / 64'd60;
    localparam int unsigned     SH_36   = 36;
    localparam longint unsigned K_7     = ((64'd1 << SH_36) + 64'd6) / 64'd7;
    localparam longint unsigned K_1460  = ((64'd1 << SH_36) + 64'd1459) / 64'd1460;
    localparam longint unsigned K_36524 = ((64'd1 << SH_36) + 64'd36523) / 64'd36524;
    localparam longint unsigned K_365   = ((64'd1 << SH_36) + 64'd364) / 64'd365;
    localparam int unsigned     SH_16   = 16;
    localparam longint unsigned K_100   = ((64'd1 << SH_16) + 64'd99) / 64'd100;
    localparam longint unsigned K_5     = ((64'd1 << SH_16) + 64'd4) / 64'd5;
    localparam int unsigned     SH_20   = 20;
    localparam longint unsigned K_153   = ((64'd1 << SH_20) + 64'd152) / 64'd153;

    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_DEC = 4'd11;

    typedef struct packed {
        logic signed [28:0] sum;
        logic signed [24:0] days;
        logic        [26:0] ms;
        logic        [24:0] dp;
        logic        [6:0]  q;
        logic signed [7:0]  cyc;
        logic        [17:0] dic;
        logic        [17:0] doe;
        logic signed [7:0]  era;
        logic        [17:0] yn;
        logic        [8:0]  yoe;
        logic        [8:0]  doym;
        logic        [3:0]  mp;
        logic        [3:0]  mon;
        logic        [4:0]  dom;
        logic        [8:0]  doy;
        logic        [2:0]  dow;
        logic               lp;
        logic               plp;
        logic signed [15:0] yr;
        logic        [4:0]  dim;
        logic        [2:0]  fdow;
        logic        [2:0]  pfdow;
        logic        [5:0]  wk;
        logic        [5:0]  wmax;
        logic signed [15:0] wyr;
        logic        [16:0] t_s;
        logic        [10:0] t_m;
        logic        [4:0]  hour;
        logic        [5:0]  minute;
        logic        [5:0]  second;
        logic        [9:0]  msec;
    } t_pipe;

    // floor(n / d) by multiplication with a rounded-up reciprocal
    function automatic longint unsigned dq(input longint unsigned n, input longint unsigned k,
                                           input int unsigned sh);
        return (n * k) >> sh;
    endfunction

    function automatic logic [2:0] mod7(input logic [17:0] n);
        logic [17:0] q;
        q = 18'(dq(64'(n), K_7, SH_36));
        return 3'(n - 18'(q * 18'd7));
    endfunction

    // year taken modulo 400
    function automatic logic leap9(input logic [8:0] y);
        return (y[1:0] == 2'd0) && (y != 9'd100) && (y != 9'd200) && (y != 9'd300);
    endfunction

    // offset that turns a day of year into its raw ISO week, from the weekday of 1 January
    function automatic logic [3:0] wk0(input logic [2:0] fdow);
        return (fdow < 3'd5) ? 4'(fdow) + 4'd6 : 4'(fdow) - 4'd1;
    endfunction

    function automatic logic [4:0] mlen(input logic [3:0] m0, input logic lp);
        logic [4:0] r;
        r = 5'd31;
        if (m0 == MON_FEB) begin
            r = 5'd28 + 5'(lp);
        end else if (m0 inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
            r = 5'd30;
        end
        return r;
    endfunction

endpackage

[src/epoch_time_to_calendar_fields.sv]
// Epoch-to-calendar converter: pipelined UTC day/millisecond to local calendar fields.
// Usage:
//   Slave stream carries one UTC instant per transaction: signed days since
//   1970-01-01 and milliseconds since UTC midnight. Master stream returns one
//   result per transaction with the local date, time of day, month length
//   and ISO week with its week-based year.
//   The configuration channel writes the zone offset (index 0) and daylight
//   offset (index 1), both signed milliseconds; write only while idle.
// Timing:
//   Fourteen register stages, one constant-reciprocal multiply or so each;
//   a result is presented from the last stage register.
//   One transaction per cycle sustained while the output is not stalled.
// Reset: synchronous, active low; empties the pipeline and clears both
//   offsets to zero.
// Stall: while the output holds a result that is not taken, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated.
module epoch_time_to_calendar_fields
    import etcf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [23:0] utc_days, [50:24] utc_ms
    input  logic [55:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [15:0] year, [19:16] month, [24:20] day_of_month, [33:25] day_of_year,
    // [36:34] day_of_week, [41:37] hour, [47:42] minute, [53:48] second,
    // [63:54] millisecond, [68:64] days_in_month, [74:69] week_of_year,
    // [90:75] week_year
    output logic [95:0]  o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_addr,
    input  logic [26:0]  i_cfg_data
);

    logic [26:0]      r_zone;
    logic [23:0]      r_dst;
    logic [NSTG-1:0]  r_vld;
    t_pipe            r_p [NSTG];
    t_pipe            n_p [NSTG];
    logic             adv;

    assign adv         = !r_vld[NSTG-1] || i_m_tready;
    assign o_s_tready  = adv;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
            r_dst  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_ZONE: r_zone <= i_cfg_data;
                CFG_DST:  r_dst  <= i_cfg_data[23:0];
                default:  r_zone <= r_zone;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p <= n_p;
        end
    end

    always_comb begin
        logic signed [2:0] c;
        logic [18:0] z;
        logic        wrap;
        logic [17:0] a;
        logic [17:0] t;
        logic [8:0]  yy;
        logic [3:0]  dz;
        logic [5:0]  w;

        // stage 0: offsets added to the millisecond count
        n_p[0]      = '0;
        n_p[0].days = {i_s_tdata[23], i_s_tdata[23:0]};
        n_p[0].sum  = $signed({2'b00, i_s_tdata[50:24]})
                    + $signed({{2{r_zone[26]}}, r_zone})
                    + $signed({{5{r_dst[23]}}, r_dst});

        // stage 1: day carry, biased day count
        n_p[1] = r_p[0];
        if (r_p[0].sum < 29'sd0) begin
            c = -3'sd1;
            n_p[1].ms = 27'(r_p[0].sum + 29'(MS_DAY));
        end else if (r_p[0].sum >= 29'(2 * MS_DAY)) begin
            c = 3'sd2;
            n_p[1].ms = 27'(r_p[0].sum - 29'(2 * MS_DAY));
        end else if (r_p[0].sum >= 29'(MS_DAY)) begin
            c = 3'sd1;
            n_p[1].ms = 27'(r_p[0].sum - 29'(MS_DAY));
        end else begin
            c = 3'sd0;
            n_p[1].ms = 27'(r_p[0].sum);
        end
        n_p[1].dp = 25'(r_p[0].days) + {{22{c[2]}}, c} + 25'(DP_OFF);

        // stage 2: cycle number, whole seconds
        n_p[2]     = r_p[1];
        n_p[2].q   = 7'(dq(64'(r_p[1].dp), K_CYC, SH_CYC));
        n_p[2].t_s = 17'(dq(64'(r_p[1].ms), K_1000, SH_1000));

        // stage 3: day in cycle, milliseconds, whole minutes
        n_p[3]      = r_p[2];
        n_p[3].dic  = 18'(r_p[2].dp - 25'(r_p[2].q) * 25'(CYC_DAYS));
        n_p[3].cyc  = $signed({1'b0, r_p[2].q}) - 8'sd58;
        n_p[3].msec = 10'(r_p[2].ms - 27'(r_p[2].t_s) * 27'd1000);
        n_p[3].t_m  = 11'(dq(64'(r_p[2].t_s), K_60, SH_60));

        // stage 4: move to March-based cycle, weekday, seconds, hours
        n_p[4] = r_p[3];
        z      = 19'(r_p[3].dic) + 19'(MAR_OFF);
        wrap   = (z >= 19'(CYC_DAYS));
        n_p[4].doe    = wrap ? 18'(z - 19'(CYC_DAYS)) : 18'(z);
        n_p[4].era    = r_p[3].cyc + 8'sd4 + $signed({7'd0, wrap});
        n_p[4].second = 6'(r_p[3].t_s - 17'(r_p[3].t_m) * 17'd60);
        n_p[4].hour   = 5'(dq(64'(r_p[3].t_m), K_60, SH_60));
        n_p[4].dow    = mod7(r_p[3].dic + 18'd4);

        // stage 5: year numerator, minutes
        n_p[5]        = r_p[4];
        n_p[5].yn     = r_p[4].doe - 18'(dq(64'(r_p[4].doe), K_1460, SH_36))
                      + 18'(dq(64'(r_p[4].doe), K_36524, SH_36))
                      - 18'(r_p[4].doe == 18'(CYC_DAYS - 1));
        n_p[5].minute = 6'(r_p[4].t_m - 11'(r_p[4].hour) * 11'd60);

        // stage 6: year of cycle
        n_p[6]     = r_p[5];
        n_p[6].yoe = 9'(dq(64'(r_p[5].yn), K_365, SH_36));

        // stage 7: day of March-based year
        n_p[7] = r_p[6];
        a = 18'(r_p[6].yoe) * 18'd365 + 18'(r_p[6].yoe >> 2)
          - 18'(dq(64'(r_p[6].yoe), K_100, SH_16));
        n_p[7].doym = 9'(r_p[6].doe - a);

        // stage 8: March-based month
        n_p[8]    = r_p[7];
        n_p[8].mp = 4'(dq(64'(r_p[7].doym) * 64'd5 + 64'd2, K_153, SH_20));

        // stage 9: day, month, year, leap flags
        n_p[9] = r_p[8];
        t  = 18'(r_p[8].mp) * 18'd153 + 18'd2;
        yy = r_p[8].yoe + 9'(r_p[8].mp >= 4'd10);
        n_p[9].dom = 5'(r_p[8].doym - 9'(dq(64'(t), K_5, SH_16)));
        n_p[9].mon = (r_p[8].mp < 4'd10) ? r_p[8].mp + 4'd2 : r_p[8].mp - 4'd10;
        n_p[9].yr  = $signed({{8{r_p[8].era[7]}}, r_p[8].era}) * 16'sd400
                   + $signed({7'd0, yy});
        n_p[9].lp  = leap9(yy);
        n_p[9].plp = leap9((yy == 9'd0) ? 9'd399 : yy - 9'd1);

        // stage 10: day of year, month length
        n_p[10]     = r_p[9];
        n_p[10].doy = (r_p[9].mon < 4'd2) ? r_p[9].doym - 9'd306
                                          : r_p[9].doym + 9'd59 + 9'(r_p[9].lp);
        n_p[10].dim = mlen(r_p[9].mon, r_p[9].lp);

        // stage 11: weekday of 1 January
        n_p[11]      = r_p[10];
        n_p[11].fdow = mod7(18'd378 + 18'(r_p[10].dow) - 18'(r_p[10].doy));

        // stage 12: raw week, week count of year, prior year's 1 January
        n_p[12] = r_p[11];
        dz = wk0(r_p[11].fdow);
        n_p[12].wk    = 6'(dq(64'(dz) + 64'(r_p[11].doy), K_7, SH_36));
        n_p[12].wmax  = 6'(dq(64'(dz) + 64'd368 + 64'(r_p[11].lp), K_7, SH_36));
        n_p[12].pfdow = mod7(18'(r_p[11].fdow) + 18'd13 - 18'(r_p[11].plp));

        // stage 13: week wrap at either end of the year, week-based year
        n_p[13] = r_p[12];
        w = r_p[12].wk;
        if (w >= r_p[12].wmax) begin
            w = 6'd1;
        end else if (w == 6'd0) begin
            w = 6'(dq(64'(wk0(r_p[12].pfdow)) + 64'd365 + 64'(r_p[12].plp), K_7, SH_36));
        end
        n_p[13].wk  = w;
        n_p[13].wyr = r_p[12].yr;
        if (r_p[12].mon == MON_JAN && w > 6'd26) begin
            n_p[13].wyr = r_p[12].yr - 16'sd1;
        end else if (r_p[12].mon == MON_DEC && w < 6'd26) begin
            n_p[13].wyr = r_p[12].yr + 16'sd1;
        end
    end

    assign o_m_tdata = {5'd0,
                        r_p[NSTG-1].wyr,
                        r_p[NSTG-1].wk,
                        r_p[NSTG-1].dim,
                        r_p[NSTG-1].msec,
                        r_p[NSTG-1].second,
                        r_p[NSTG-1].minute,
                        r_p[NSTG-1].hour,
                        r_p[NSTG-1].dow,
                        r_p[NSTG-1].doy + 9'd1,
                        r_p[NSTG-1].dom + 5'd1,
                        r_p[NSTG-1].mon + 4'd1,
                        r_p[NSTG-1].yr};

endmodule

[bench/tb_top.sv]
// Testbench for the epoch-to-calendar converter: randomised streams checked against a predictor.
module tb_top
    import etcf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MS_PER_DAY = 86400000;
    localparam longint DAYS_PER_CYCLE = 146097;
    localparam longint EPOCH_YEAR = 1970;

    // result layout, most significant field first
    typedef struct packed {
        logic [4:0]         pad;
        logic signed [15:0] week_year;
        logic [5:0]         week_of_year;
        logic [4:0]         days_in_month;
        logic [9:0]         millisecond;
        logic [5:0]         second;
        logic [5:0]         minute;
        logic [4:0]         hour;
        logic [2:0]         day_of_week;
        logic [8:0]         day_of_year;
        logic [4:0]         day_of_month;
        logic [3:0]         month;
        logic signed [15:0] year;
    } t_cal;

    typedef struct {
        logic signed [23:0] days;
        logic [26:0]        ms;
        bit                 drain_first;
    } t_instant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_addr = 1'b0;
    logic [26:0] i_cfg_data = '0;

    epoch_time_to_calendar_fields dut (.*);

    always #4 i_clk = ~i_clk;

    logic signed [26:0] zone_ms = '0;
    logic signed [23:0] dst_ms = '0;

    t_instant pending_q[$];
    t_cal     dates_due_q[$];
    int       err_cnt = 0;
    int       in_cnt = 0;
    int       out_cnt = 0;
    int       cfg_cnt = 0;
    int       rx_hold = 0;
    bit       no_idle = 1'b0;
    bit       taken = 1'b0;
    int       tx_gap = 0;
    int       rx_gap = 0;

    function automatic bit is_leap(longint y);
        longint r400, r100, r4;
        r400 = ((y % 400) + 400) % 400;
        r100 = ((y % 100) + 100) % 100;
        r4 = ((y % 4) + 4) % 4;
        return r400 == 0 || (r100 != 0 && r4 == 0);
    endfunction

    function automatic longint month_len(longint y, longint m0);
        if (m0 == 1) return is_leap(y) ? 29 : 28;
        if (m0 == 3 || m0 == 5 || m0 == 8 || m0 == 10) return 30;
        return 31;
    endfunction

    function automatic longint week0_days(longint fdow);
        return (fdow < 5) ? fdow + 6 : fdow - 1;
    endfunction

    function automatic t_cal local_calendar(logic signed [23:0] utc_days, logic [26:0] utc_ms);
        longint days, ms, c, cyc, dic, yic, diy, doy, mon, dim, dom, dow;
        longint fdow, wk, wmax, yr, wyr, pdiy, pfdow;
        t_cal r;
        days = utc_days;
        ms = longint'(utc_ms) + longint'(zone_ms) + longint'(dst_ms);
        c = ms / MS_PER_DAY;
        ms = ms % MS_PER_DAY;
        if (ms < 0) begin
            ms += MS_PER_DAY;
            c -= 1;
        end
        days += c;
        cyc = days / DAYS_PER_CYCLE;
        dic = days % DAYS_PER_CYCLE;
        if (dic < 0) begin
            dic += DAYS_PER_CYCLE;
            cyc -= 1;
        end
        yic = 0;
        diy = 365;
        doy = dic;
        while (doy >= diy) begin
            doy -= diy;
            yic += 1;
            diy = is_leap(EPOCH_YEAR + yic) ? 366 : 365;
        end
        mon = 0;
        dim = 31;
        dom = doy;
        while (dom >= dim) begin
            dom -= dim;
            mon += 1;
            dim = month_len(EPOCH_YEAR + yic, mon);
        end
        dow = (dic + 4) % 7;
        fdow = (378 + dow - doy) % 7;
        wk = (week0_days(fdow) + doy) / 7;
        wmax = (week0_days(fdow) + diy + 3) / 7;
        if (wk >= wmax) wk = 1;
        if (wk < 1) begin
            pdiy = is_leap(EPOCH_YEAR + yic - 1) ? 366 : 365;
            pfdow = (378 + fdow - pdiy) % 7;
            wk = (week0_days(pfdow) + pdiy) / 7;
        end
        yr = EPOCH_YEAR + cyc * 400 + yic;
        wyr = yr;
        if (mon == 0 && wk > 26) wyr = yr - 1;
        if (mon == 11 && wk < 26) wyr = yr + 1;
        r = '0;
        r.year = 16'(yr);
        r.month = 4'(mon + 1);
        r.day_of_month = 5'(dom + 1);
        r.day_of_year = 9'(doy + 1);
        r.day_of_week = 3'(dow);
        r.hour = 5'(ms / 3600000);
        r.minute = 6'((ms / 60000) % 60);
        r.second = 6'((ms / 1000) % 60);
        r.millisecond = 10'(ms % 1000);
        r.days_in_month = 5'(dim);
        r.week_of_year = 6'(wk);
        r.week_year = 16'(wyr);
        return r;
    endfunction

    task automatic report(string what, longint got, longint exp);
        err_cnt++;
        if (err_cnt <= 40)
            $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, exp);
    endtask

    task automatic compare_dates(t_cal got, t_cal exp);
        if (got.year !== exp.year) report("year", got.year, exp.year);
        if (got.month !== exp.month) report("month", got.month, exp.month);
        if (got.day_of_month !== exp.day_of_month)
            report("day_of_month", got.day_of_month, exp.day_of_month);
        if (got.day_of_year !== exp.day_of_year)
            report("day_of_year", got.day_of_year, exp.day_of_year);
        if (got.day_of_week !== exp.day_of_week)
            report("day_of_week", got.day_of_week, exp.day_of_week);
        if (got.hour !== exp.hour) report("hour", got.hour, exp.hour);
        if (got.minute !== exp.minute) report("minute", got.minute, exp.minute);
        if (got.second !== exp.second) report("second", got.second, exp.second);
        if (got.millisecond !== exp.millisecond)
            report("millisecond", got.millisecond, exp.millisecond);
        if (got.days_in_month !== exp.days_in_month)
            report("days_in_month", got.days_in_month, exp.days_in_month);
        if (got.week_of_year !== exp.week_of_year)
            report("week_of_year", got.week_of_year, exp.week_of_year);
        if (got.week_year !== exp.week_year)
            report("week_year", got.week_year, exp.week_year);
    endtask

    // accepted transactions on both streams
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            taken = 1'b1;
            in_cnt++;
            dates_due_q.push_back(local_calendar(i_s_tdata[23:0], i_s_tdata[50:24]));
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            out_cnt++;
            if (dates_due_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                compare_dates(t_cal'(o_m_tdata), dates_due_q.pop_front());
            end
        end
    end

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_s_tvalid && !taken)) begin
            taken = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_tvalid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && dates_due_q.size() != 0)) begin
                i_s_tvalid <= 1'b0;
            end else begin
                t_instant it;
                it = pending_q.pop_front();
                i_s_tdata <= {5'b0, it.ms, it.days};
                i_s_tvalid <= 1'b1;
                tx_gap = pick_gap();
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            rx_gap = pick_gap();
        end
    end

    task automatic add_instant(longint d, longint m, bit drain = 1'b0);
        t_instant it;
        it.days = 24'(d);
        it.ms = 27'(m);
        it.drain_first = drain;
        pending_q.push_back(it);
    endtask

    task automatic add_random(int n);
        longint d, m;
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1: d = $urandom() & 24'hffffff;
                2: d = longint'($urandom_range(0, 2000)) - 1000 + 20088;
                default: d = longint'($urandom_range(0, 1600000)) - 800000;
            endcase
            case ($urandom_range(0, 9))
                0: m = $urandom() & 27'h7ffffff;
                1: m = $urandom_range(0, 3);
                2: m = MS_PER_DAY - 1 - $urandom_range(0, 3);
                default: m = $urandom_range(0, MS_PER_DAY - 1);
            endcase
            add_instant(d, m, $urandom_range(0, 59) == 0);
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || i_s_tvalid || dates_due_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [26:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_ZONE) zone_ms = val;
        else dst_ms = val[23:0];
        cfg_cnt++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [26:0] zone, logic [26:0] dst, int n);
        wait_idle();
        write_reg(CFG_ZONE, zone);
        write_reg(CFG_DST, dst);
        add_random(n);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, leap days, year-boundary weeks
        add_instant(-8388608, 0);
        add_instant(8388607, 86399999);
        add_instant(0, 0);
        add_instant(-1, 86399999);
        add_instant(0, 134217727);
        add_instant(-8388608, 134217727);
        add_instant(8388607, 0);
        add_instant(11016, 43200000);   // leap day 2000
        add_instant(19416, 1000);       // end of February, common year
        add_instant(-25509, 5);         // around February 1900
        add_instant(18628, 0);          // early January in last year's week 53
        add_instant(18629, 0);
        add_instant(20088, 3723004);    // late December in next year's week 1
        add_instant(20089, 0);
        add_instant(16800, 0, 1'b1);    // sender drains first
        add_instant(16801, 59999);
        add_random(60);
        wait_idle();

        no_idle = 1'b1;
        run_phase(27'(50400000), 27'(7200000), 90);
        wait_idle();
        no_idle = 1'b0;

        // long receiver stall while the sender keeps offering
        write_reg(CFG_ZONE, 27'(-50400000));
        write_reg(CFG_DST, 27'(-7200000));
        add_instant(0, 0);
        add_instant(-1, 86399999);
        add_random(90);
        rx_hold = 400;

        run_phase(27'($urandom()), 27'($urandom()), 90);
        run_phase(27'($urandom_range(0, 100800000)) - 27'(50400000),
                  27'($urandom_range(0, 14400000)) - 27'(7200000), 90);
        run_phase(27'(3600000), 27'(-3600000), 90);
        wait_idle();
        repeat (30) @(posedge i_clk);

        $display("Covered %0d instants and %0d results over %0d register writes,",
                 in_cnt, out_cnt, cfg_cnt);
        $display("offsets at both extremes, out-of-range register bits and long stalls.");
        if (err_cnt == 0 && dates_due_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
